// File: design/twm_pkg.sv
// Shared types, constants and helpers for the toy word machine.
// No dependencies; used by twm_ctrl, twm_dpath and the top level.
package twm_pkg;

  localparam int MEM_WORDS_DEF  = 100;
  localparam int CARD_WORDS_DEF = 10;
  localparam int BLOCK_STRIDE   = 10;
  localparam int ADDR_W         = 7;
  localparam int CNT_W          = 4;

  localparam logic [2:0] OP_NEW_JOB = 3'd0;
  localparam logic [2:0] OP_LOAD    = 3'd1;
  localparam logic [2:0] OP_START   = 3'd2;
  localparam logic [2:0] OP_DATA    = 3'd3;
  localparam logic [2:0] OP_STEP    = 3'd4;

  localparam logic [1:0] KIND_PRINT = 2'd0;
  localparam logic [1:0] KIND_HALT  = 2'd1;
  localparam logic [1:0] KIND_FAULT = 2'd2;

  localparam logic [1:0] FAULT_ADDR = 2'd0;
  localparam logic [1:0] FAULT_IC   = 2'd1;
  localparam logic [1:0] FAULT_FULL = 2'd2;

  localparam logic [7:0] CH_ZERO = 8'd48;
  localparam logic [7:0] CH_NINE = 8'd57;
  localparam logic [7:0] CH_G    = 8'h47;
  localparam logic [7:0] CH_D    = 8'h44;
  localparam logic [7:0] CH_P    = 8'h50;
  localparam logic [7:0] CH_H    = 8'h48;
  localparam logic [7:0] CH_L    = 8'h4C;
  localparam logic [7:0] CH_R    = 8'h52;
  localparam logic [7:0] CH_S    = 8'h53;
  localparam logic [7:0] CH_C    = 8'h43;
  localparam logic [7:0] CH_B    = 8'h42;
  localparam logic [7:0] CH_T    = 8'h54;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_RUN,
    MODE_WAIT
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_OPER,
    ST_PRINT,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic [2:0]  op;
    logic [31:0] word;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] out_word;
    logic [1:0]  fault_code;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic       clear_job;
    logic       load_wr;
    logic       start;
    logic       data_wr;
    logic       fetch;
    logic       mode_wr;
    mode_t      mode_val;
    logic       gd_set;
    logic       pd_start;
    logic       pd_next;
    logic       sr_wr;
    logic       op_rd;
    logic       lr_load;
    logic       cr_set;
    logic       bt_jump;
    logic       out_load;
    logic [1:0] out_kind;
    logic [1:0] out_code;
    logic       out_print;
    logic       out_last;
  } cmd_t;

  typedef struct packed {
    mode_t mode;
    logic  lp_full;
    logic  ic_over;
    logic  out_free;
    logic  is_gdpd;
    logic  is_get;
    logic  is_h;
    logic  is_lr;
    logic  is_sr;
    logic  is_cr;
    logic  is_bt;
    logic  blk_ok;
    logic  addr_ok;
    logic  cflag;
    logic  pd_last;
  } sts_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

endpackage

// File: design/twm_dpath.sv
// Datapath of the toy word machine: program memory with per-word valid bits,
// machine registers, instruction decode and the output register. Uses twm_pkg.
module twm_dpath #(
  parameter int MEM_WORDS  = twm_pkg::MEM_WORDS_DEF,
  parameter int CARD_WORDS = twm_pkg::CARD_WORDS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [31:0]        in_word,
  input  twm_pkg::cmd_t      cmd,
  output twm_pkg::sts_t      sts,
  output logic               out_valid,
  input  logic               out_stall,
  output twm_pkg::out_item_t out_data
);
  import twm_pkg::*;

  localparam int AW = $clog2(MEM_WORDS);

  logic [31:0]          mem [MEM_WORDS];
  logic [MEM_WORDS-1:0] vld;
  logic [31:0]          rd_data;
  logic                 rd_hit;
  logic [31:0]          rdata;

  logic [ADDR_W-1:0] ic;
  logic [ADDR_W-1:0] lp;
  logic [ADDR_W-1:0] base;
  logic [ADDR_W-1:0] pptr;
  logic [CNT_W-1:0]  cnt;
  logic [CNT_W-1:0]  cnt_inc;
  logic [CNT_W-1:0]  pcnt;
  logic [31:0]       gr;
  logic              cflag;
  mode_t             mode;

  logic [7:0]        c0, c1, c2, c3, d2, d3;
  logic              dig2, dig3;
  logic [ADDR_W-1:0] blk_addr;
  logic [ADDR_W-1:0] op_addr;
  logic [ADDR_W:0]   data_addr;
  logic              data_ok;

  logic              wr_en, rd_en;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [31:0]       wdata;

  assign rdata = rd_hit ? rd_data : '0;

  assign c0 = rdata[31:24];
  assign c1 = rdata[23:16];
  assign c2 = rdata[15:8];
  assign c3 = rdata[7:0];
  assign d2 = c2 - CH_ZERO;
  assign d3 = c3 - CH_ZERO;
  assign dig2 = is_digit(c2);
  assign dig3 = is_digit(c3);
  assign blk_addr = {3'b000, d2[3:0]} * ADDR_W'(BLOCK_STRIDE);
  assign op_addr  = blk_addr + {3'b000, d3[3:0]};

  assign data_addr = {1'b0, base} + {4'b0000, cnt};
  assign data_ok   = data_addr < (ADDR_W + 1)'(MEM_WORDS);
  assign cnt_inc   = cnt + CNT_W'(1);

  always_comb begin
    wr_en = cmd.load_wr | (cmd.data_wr & data_ok) | cmd.sr_wr;
    waddr = lp;
    wdata = in_word;
    if (cmd.data_wr) begin
      waddr = data_addr[ADDR_W-1:0];
    end else if (cmd.sr_wr) begin
      waddr = op_addr;
      wdata = gr;
    end
  end

  always_comb begin
    rd_en = cmd.fetch | cmd.pd_start | cmd.pd_next | cmd.op_rd;
    raddr = ic;
    if (cmd.pd_start) begin
      raddr = blk_addr;
    end else if (cmd.pd_next) begin
      raddr = pptr + ADDR_W'(1);
    end else if (cmd.op_rd) begin
      raddr = op_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[waddr[AW-1:0]] <= wdata;
    end
    if (rd_en) begin
      rd_data <= mem[raddr[AW-1:0]];
      rd_hit  <= vld[raddr[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear_job) begin
      vld <= '0;
    end else if (wr_en) begin
      vld[waddr[AW-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear_job) begin
      ic    <= '0;
      lp    <= '0;
      base  <= '0;
      cnt   <= '0;
      gr    <= '0;
      cflag <= 1'b0;
      mode  <= MODE_IDLE;
    end else begin
      if (cmd.load_wr) begin
        lp <= lp + ADDR_W'(1);
      end
      if (cmd.start) begin
        ic   <= '0;
        cnt  <= '0;
        mode <= MODE_RUN;
      end
      if (cmd.data_wr) begin
        cnt <= cnt_inc;
        if (cnt_inc >= CNT_W'(CARD_WORDS)) begin
          mode <= MODE_RUN;
        end
      end
      if (cmd.fetch) begin
        ic <= ic + ADDR_W'(1);
      end
      if (cmd.mode_wr) begin
        mode <= cmd.mode_val;
      end
      if (cmd.gd_set) begin
        base <= blk_addr;
        cnt  <= '0;
        mode <= MODE_WAIT;
      end
      if (cmd.lr_load) begin
        gr <= rdata;
      end
      if (cmd.cr_set) begin
        cflag <= (rdata == gr);
      end
      if (cmd.bt_jump) begin
        ic <= op_addr;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pd_start) begin
      pptr <= blk_addr;
      pcnt <= '0;
    end else if (cmd.pd_next) begin
      pptr <= pptr + ADDR_W'(1);
      pcnt <= pcnt + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data.kind       <= cmd.out_kind;
      out_data.out_word   <= cmd.out_print ? rdata : '0;
      out_data.fault_code <= cmd.out_code;
      out_data.last       <= cmd.out_last;
    end
  end

  always_comb begin
    sts.mode     = mode;
    sts.lp_full  = lp >= ADDR_W'(MEM_WORDS);
    sts.ic_over  = ic >= ADDR_W'(MEM_WORDS);
    sts.out_free = !out_valid || !out_stall;
    sts.is_gdpd  = ((c0 == CH_G) || (c0 == CH_P)) && (c1 == CH_D);
    sts.is_get   = c0 == CH_G;
    sts.is_h     = c0 == CH_H;
    sts.is_lr    = (c0 == CH_L) && (c1 == CH_R);
    sts.is_sr    = (c0 == CH_S) && (c1 == CH_R);
    sts.is_cr    = (c0 == CH_C) && (c1 == CH_R);
    sts.is_bt    = (c0 == CH_B) && (c1 == CH_T);
    sts.blk_ok   = dig2 &&
                   (({1'b0, blk_addr} + (ADDR_W + 1)'(CARD_WORDS)) <=
                    (ADDR_W + 1)'(MEM_WORDS));
    sts.addr_ok  = dig2 && dig3 && (op_addr < ADDR_W'(MEM_WORDS));
    sts.cflag    = cflag;
    sts.pd_last  = pcnt == CNT_W'(CARD_WORDS - 1);
  end

`ifndef SYNTHESIS
  a_data_only_waiting: assert property (@(posedge clk) disable iff (rst)
    cmd.data_wr |-> mode == MODE_WAIT)
    else $error("data beat written while not waiting for data");

  a_load_not_full: assert property (@(posedge clk) disable iff (rst)
    cmd.load_wr |-> lp < ADDR_W'(MEM_WORDS))
    else $error("program word written past end of memory");

  a_single_ends: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.kind != KIND_PRINT) |-> out_data.last)
    else $error("halt or fault beat not marked last");
`endif

endmodule

// File: design/twm_ctrl.sv
// Sequencing controller of the toy word machine: decides per input beat and
// per instruction phase which datapath commands fire. Uses twm_pkg.
module twm_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [2:0]    in_op,
  input  twm_pkg::sts_t sts,
  output twm_pkg::cmd_t cmd
);
  import twm_pkg::*;

  state_t     state, state_next;
  logic [1:0] res_kind, res_kind_next;
  logic [1:0] res_code, res_code_next;
  logic       oper_cr, oper_cr_next;
  logic       mem_op;

  assign mem_op = sts.is_lr || sts.is_sr || sts.is_cr || (sts.is_bt && sts.cflag);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    res_kind <= res_kind_next;
    res_code <= res_code_next;
    oper_cr  <= oper_cr_next;
  end

  always_comb begin
    state_next    = state;
    res_kind_next = res_kind;
    res_code_next = res_code;
    oper_cr_next  = oper_cr;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          case (in_op)
            OP_LOAD: begin
              if (sts.lp_full) begin
                state_next    = ST_RESULT;
                res_kind_next = KIND_FAULT;
                res_code_next = FAULT_FULL;
              end
            end
            OP_STEP: begin
              if (sts.mode == MODE_RUN) begin
                if (sts.ic_over) begin
                  state_next    = ST_RESULT;
                  res_kind_next = KIND_FAULT;
                  res_code_next = FAULT_IC;
                end else begin
                  state_next = ST_DECODE;
                end
              end
            end
            default: ;
          endcase
        end
      end
      ST_DECODE: begin
        state_next = ST_IDLE;
        if (sts.is_gdpd) begin
          if (!sts.blk_ok) begin
            state_next    = ST_RESULT;
            res_kind_next = KIND_FAULT;
            res_code_next = FAULT_ADDR;
          end else if (!sts.is_get) begin
            state_next = ST_PRINT;
          end
        end else if (sts.is_h) begin
          state_next    = ST_RESULT;
          res_kind_next = KIND_HALT;
          res_code_next = '0;
        end else if (mem_op && !sts.addr_ok) begin
          state_next    = ST_RESULT;
          res_kind_next = KIND_FAULT;
          res_code_next = FAULT_ADDR;
        end else if (sts.is_lr || sts.is_cr) begin
          state_next   = ST_OPER;
          oper_cr_next = sts.is_cr;
        end
      end
      ST_OPER: begin
        state_next = ST_IDLE;
      end
      ST_PRINT: begin
        if (sts.out_free && sts.pd_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_RESULT: begin
        if (sts.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = state != ST_IDLE;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          case (in_op)
            OP_NEW_JOB: cmd.clear_job = 1'b1;
            OP_LOAD:    cmd.load_wr   = !sts.lp_full;
            OP_START:   cmd.start     = 1'b1;
            OP_DATA:    cmd.data_wr   = sts.mode == MODE_WAIT;
            OP_STEP: begin
              if (sts.mode == MODE_RUN) begin
                if (sts.ic_over) begin
                  cmd.mode_wr  = 1'b1;
                  cmd.mode_val = MODE_IDLE;
                end else begin
                  cmd.fetch = 1'b1;
                end
              end
            end
            default: ;
          endcase
        end
      end
      ST_DECODE: begin
        if (sts.is_gdpd) begin
          if (!sts.blk_ok) begin
            cmd.mode_wr  = 1'b1;
            cmd.mode_val = MODE_IDLE;
          end else if (sts.is_get) begin
            cmd.gd_set = 1'b1;
          end else begin
            cmd.pd_start = 1'b1;
          end
        end else if (sts.is_h || (mem_op && !sts.addr_ok)) begin
          cmd.mode_wr  = 1'b1;
          cmd.mode_val = MODE_IDLE;
        end else if (mem_op) begin
          cmd.sr_wr   = sts.is_sr;
          cmd.op_rd   = sts.is_lr || sts.is_cr;
          cmd.bt_jump = sts.is_bt;
        end
      end
      ST_OPER: begin
        cmd.lr_load = !oper_cr;
        cmd.cr_set  = oper_cr;
      end
      ST_PRINT: begin
        if (sts.out_free) begin
          cmd.out_load  = 1'b1;
          cmd.out_kind  = KIND_PRINT;
          cmd.out_print = 1'b1;
          cmd.out_last  = sts.pd_last;
          cmd.pd_next   = !sts.pd_last;
        end
      end
      ST_RESULT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_kind = res_kind;
          cmd.out_code = res_code;
          cmd.out_last = 1'b1;
        end
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_load_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> sts.out_free)
    else $error("output register overwritten while holding a beat");

  a_fetch_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.fetch |-> (!sts.ic_over && sts.mode == MODE_RUN))
    else $error("instruction fetched out of range or while not running");

  a_print_ends: assert property (@(posedge clk) disable iff (rst)
    (state == ST_PRINT && cmd.out_load && cmd.out_last) |=> state == ST_IDLE)
    else $error("print sequence did not finish on its last word");
`endif

endmodule

// File: design/toy_word_machine_executor_top.sv
// Toy word machine executor, top level.
// Input channel: in_valid / in_stall / in_data (op, word). Output channel:
// out_valid / out_stall / out_data (kind, out_word, fault_code, last).
// A beat moves when valid is high and stall is low at a rising edge.
// New job, start, data and accepted load beats are taken in the idle state;
// a load into a full memory passes to the result state to give its fault.
// A step beat fetches the instruction, then decodes it and accesses the
// operand; LR and CR add an operand state for the registered operand read
// from the program memory. Halt and decode faults go from decode to the
// result state, which loads the result. PD streams CARD_WORDS printed words
// after fetch and decode, one per cycle unless the output stalls, last marked.
// in_stall is high while a step or a fault result is in progress; the next
// beat is taken while a result still sits in the output register. When
// out_stall is high the output register holds and the sequencer waits on it
// while it holds a beat. Reset (rst, synchronous) empties the output register,
// returns the machine to idle and clears all machine registers but pptr and
// pcnt; memory words read as zero until written, through per-word valid bits
// that reset and new job clear. Depends on twm_pkg, twm_ctrl and twm_dpath.
module toy_word_machine_executor_top #(
  parameter int MEM_WORDS  = twm_pkg::MEM_WORDS_DEF,
  parameter int CARD_WORDS = twm_pkg::CARD_WORDS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  twm_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output twm_pkg::out_item_t out_data
);
  import twm_pkg::*;

  cmd_t cmd;
  sts_t sts;

  twm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_op    (in_data.op),
    .sts      (sts),
    .cmd      (cmd)
  );

  twm_dpath #(
    .MEM_WORDS  (MEM_WORDS),
    .CARD_WORDS (CARD_WORDS)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .in_word   (in_data.word),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// File: verif/toy_word_machine_executor_top_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for toy_word_machine_executor_top: a directed program
// followed by random jobs, each result beat checked against an in-bench machine.
// Depends on twm_pkg and the executor RTL.
module toy_word_machine_executor_top_tb;
  import twm_pkg::*;

  localparam int NWORDS     = MEM_WORDS_DEF;
  localparam int NCARD      = CARD_WORDS_DEF;
  localparam int CHK        = 0;
  localparam int GEN        = 1;
  localparam int RAND_ITEMS = 500;

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  // two copies of the machine: CHK follows accepted beats, GEN runs ahead
  // while the stimulus is built
  logic [31:0] mem_w  [2][NWORDS];
  logic [31:0] reg_r  [2];
  logic        flag_c [2];
  logic [6:0]  ic_r   [2];
  logic [6:0]  lp_r   [2];
  mode_t       mode_r [2];
  logic [6:0]  base_r [2];
  logic [3:0]  cnt_r  [2];

  in_item_t  item_q [$];
  out_item_t want_q [$];

  int   n_real = 0;
  int   n_err = 0;
  int   n_in_beats = 0;
  int   n_results = 0;
  int   n_prints = 0;
  int   n_halts = 0;
  int   n_faults = 0;
  int   in_gap = 0;
  int   out_gap = 0;
  int   hold_left = 0;
  logic hold_done = 1'b0;
  logic quiet = 1'b0;

  toy_word_machine_executor_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #4 clk = ~clk;

  function automatic void clear_machine(input int m);
    for (int i = 0; i < NWORDS; i++) mem_w[m][i] = '0;
    reg_r[m]  = '0;
    flag_c[m] = 1'b0;
    ic_r[m]   = '0;
    lp_r[m]   = '0;
    mode_r[m] = MODE_IDLE;
    base_r[m] = '0;
    cnt_r[m]  = '0;
  endfunction

  function automatic void post_result(input int m, input logic [1:0] kind,
                                      input logic [31:0] w, input logic [1:0] code,
                                      input logic fin);
    out_item_t r;
    r.kind       = kind;
    r.out_word   = w;
    r.fault_code = code;
    r.last       = fin;
    if (m == CHK) want_q.push_back(r);
  endfunction

  function automatic void raise_fault(input int m, input logic [1:0] code);
    mode_r[m] = MODE_IDLE;
    post_result(m, KIND_FAULT, '0, code, 1'b1);
  endfunction

  function automatic void machine_apply(input int m, input in_item_t it);
    logic [31:0] ir;
    logic [7:0]  c0, c1, c2, c3;
    logic        d2, d3;
    int          addr;
    case (it.op)
      OP_NEW_JOB: clear_machine(m);
      OP_LOAD: begin
        if (lp_r[m] >= NWORDS) begin
          post_result(m, KIND_FAULT, '0, FAULT_FULL, 1'b1);
        end else begin
          mem_w[m][lp_r[m]] = it.word;
          lp_r[m] = lp_r[m] + 7'd1;
        end
      end
      OP_START: begin
        ic_r[m]   = '0;
        cnt_r[m]  = '0;
        mode_r[m] = MODE_RUN;
      end
      OP_DATA: begin
        if (mode_r[m] == MODE_WAIT) begin
          addr = int'(base_r[m]) + int'(cnt_r[m]);
          if (addr < NWORDS) mem_w[m][addr] = it.word;
          cnt_r[m] = cnt_r[m] + 4'd1;
          if (cnt_r[m] >= NCARD) mode_r[m] = MODE_RUN;
        end
      end
      OP_STEP: begin
        if (mode_r[m] == MODE_RUN) begin
          if (ic_r[m] >= NWORDS) begin
            raise_fault(m, FAULT_IC);
          end else begin
            ir = mem_w[m][ic_r[m]];
            ic_r[m] = ic_r[m] + 7'd1;
            {c0, c1, c2, c3} = ir;
            d2 = (c2 >= CH_ZERO) && (c2 <= CH_NINE);
            d3 = (c3 >= CH_ZERO) && (c3 <= CH_NINE);
            if ((c0 == CH_G || c0 == CH_P) && c1 == CH_D) begin
              addr = (int'(c2) - int'(CH_ZERO)) * 10;
              if (!d2 || addr + NCARD > NWORDS) begin
                raise_fault(m, FAULT_ADDR);
              end else if (c0 == CH_G) begin
                base_r[m] = 7'(addr);
                cnt_r[m]  = '0;
                mode_r[m] = MODE_WAIT;
              end else begin
                for (int n = 0; n < NCARD; n++)
                  post_result(m, KIND_PRINT, mem_w[m][addr + n], '0, n == NCARD - 1);
              end
            end else if (c0 == CH_H) begin
              mode_r[m] = MODE_IDLE;
              post_result(m, KIND_HALT, '0, '0, 1'b1);
            end else if ((c1 == CH_R && (c0 == CH_L || c0 == CH_S || c0 == CH_C)) ||
                         (c0 == CH_B && c1 == CH_T && flag_c[m])) begin
              addr = (int'(c2) - int'(CH_ZERO)) * 10 + int'(c3) - int'(CH_ZERO);
              if (!d2 || !d3 || addr >= NWORDS) raise_fault(m, FAULT_ADDR);
              else if (c0 == CH_L) reg_r[m] = mem_w[m][addr];
              else if (c0 == CH_S) mem_w[m][addr] = reg_r[m];
              else if (c0 == CH_C) flag_c[m] = (mem_w[m][addr] == reg_r[m]);
              else ic_r[m] = 7'(addr);
            end
          end
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void push_item(input logic [2:0] op, input logic [31:0] w);
    in_item_t it;
    it.op   = op;
    it.word = w;
    if (op == OP_NEW_JOB || op == OP_LOAD || op == OP_START ||
        (op == OP_DATA && mode_r[GEN] == MODE_WAIT) ||
        (op == OP_STEP && mode_r[GEN] == MODE_RUN)) n_real++;
    machine_apply(GEN, it);
    item_q.push_back(it);
  endfunction

  function automatic logic [31:0] rand_instr(input int span);
    logic [7:0] a, b;
    int         t;
    t = $urandom_range(0, span - 1);
    a = CH_ZERO + 8'($urandom_range(0, 9));
    b = CH_ZERO + 8'($urandom_range(0, 9));
    if ($urandom_range(0, 19) == 0) a = 8'($urandom);
    if ($urandom_range(0, 19) == 0) b = 8'($urandom);
    case ($urandom_range(0, 15))
      0, 1:    return {CH_G, CH_D, a, 8'($urandom)};
      2, 3, 4: return {CH_P, CH_D, a, b};
      5:       return {CH_H, 24'($urandom)};
      6, 7:    return {CH_L, CH_R, a, b};
      8, 9:    return {CH_S, CH_R, a, b};
      10, 11:  return {CH_C, CH_R, a, b};
      12, 13: begin
        if ($urandom_range(0, 3) == 0) return {CH_B, CH_T, a, b};
        return {CH_B, CH_T, CH_ZERO + 8'(t / 10), CH_ZERO + 8'(t % 10)};
      end
      default: return $urandom;
    endcase
  endfunction

  // new job, program load, start, then steps and data cards as the machine asks, with the odd random beat mixed in
  function automatic void build_job(input bit fill);
    int len, steps;
    len = fill ? $urandom_range(NWORDS, NWORDS + 3) : $urandom_range(2, 16);
    push_item(OP_NEW_JOB, $urandom);
    for (int i = 0; i < len; i++) push_item(OP_LOAD, rand_instr(len));
    push_item(OP_START, $urandom);
    steps = 0;
    while (mode_r[GEN] != MODE_IDLE && steps < (fill ? 160 : 40)) begin
      steps++;
      if ($urandom_range(0, 24) == 0)
        push_item(3'($urandom_range(0, 7)), $urandom);
      else if ($urandom_range(0, 59) == 0)
        break;
      else if (mode_r[GEN] == MODE_WAIT)
        push_item(OP_DATA, ($urandom_range(0, 3) == 0) ? 32'h0 : 32'($urandom));
      else
        push_item(OP_STEP, $urandom);
    end
  endfunction

  task automatic note_mismatch(input string what);
    n_err++;
    $display("%0t mismatch: %s", $time, what);
  endtask

  // input driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_gap   <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        machine_apply(CHK, in_data);
        n_in_beats <= n_in_beats + 1;
      end
      quiet <= (item_q.size() < 60);
      if (in_valid && in_stall) begin
        // stalled beat holds
      end else if (in_gap != 0) begin
        in_valid <= 1'b0;
        in_gap   <= in_gap - 1;
      end else if (item_q.size() != 0) begin
        if (!quiet && $urandom_range(0, 9) == 0) begin
          in_valid <= 1'b0;
          in_gap   <= $urandom_range(0, 6);
        end else begin
          in_valid <= 1'b1;
          in_data  <= item_q.pop_front();
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // long receiver hold-off, once, so the block backs up into its input
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && n_in_beats >= 150) begin
      hold_left <= 400;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // result monitor and output stall
  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      out_stall <= 1'b0;
      out_gap   <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        n_results++;
        case (out_data.kind)
          KIND_PRINT: n_prints++;
          KIND_HALT:  n_halts++;
          default:    n_faults++;
        endcase
        if (want_q.size() == 0) begin
          note_mismatch($sformatf("result %h with nothing expected", out_data));
        end else begin
          want = want_q.pop_front();
          if (out_data.kind !== want.kind)
            note_mismatch($sformatf("kind %0d, want %0d", out_data.kind, want.kind));
          if (out_data.out_word !== want.out_word)
            note_mismatch($sformatf("out_word %h, want %h", out_data.out_word,
                                    want.out_word));
          if (out_data.fault_code !== want.fault_code)
            note_mismatch($sformatf("fault_code %0d, want %0d", out_data.fault_code,
                                    want.fault_code));
          if (out_data.last !== want.last)
            note_mismatch($sformatf("last %0b, want %0b", out_data.last, want.last));
        end
      end
      if (hold_left != 0) begin
        out_stall <= 1'b1;
      end else if (out_gap != 0) begin
        out_stall <= 1'b1;
        out_gap   <= out_gap - 1;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        out_stall <= 1'b1;
        out_gap   <= $urandom_range(0, 6);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    clear_machine(CHK);
    clear_machine(GEN);

    // directed: ignored step, card read and print of the top block, LR/CR,
    // taken branch to the last word, then counter overflow
    push_item(OP_STEP, 32'hFFFF_FFFF);
    push_item(OP_NEW_JOB, 32'h0);
    push_item(OP_LOAD, {CH_G, CH_D, CH_NINE, CH_ZERO});
    push_item(OP_LOAD, {CH_P, CH_D, CH_NINE, CH_ZERO});
    push_item(OP_LOAD, {CH_L, CH_R, CH_NINE, CH_ZERO + 8'd7});
    push_item(OP_LOAD, {CH_C, CH_R, CH_NINE, CH_ZERO + 8'd8});
    push_item(OP_LOAD, {CH_B, CH_T, CH_NINE, CH_NINE});
    push_item(OP_START, 32'hFFFF_FFFF);
    push_item(OP_STEP, 32'h0);
    push_item(OP_DATA, 32'h0000_0000);
    push_item(OP_DATA, 32'hFFFF_FFFF);
    push_item(OP_DATA, 32'h8000_0000);
    push_item(OP_DATA, 32'h0000_0001);
    for (int i = 0; i < 3; i++) push_item(OP_DATA, $urandom);
    for (int i = 0; i < 3; i++) push_item(OP_DATA, 32'hFFFF_FFFF);
    for (int i = 0; i < 6; i++) push_item(OP_STEP, $urandom);

    n_real = 0;
    for (int j = 0; n_real < RAND_ITEMS; j++) build_job(j == 3);

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    while (item_q.size() != 0 || in_valid || want_q.size() != 0) @(negedge clk);
    repeat (40) @(posedge clk);

    $display("%0d input beats driven; %0d results seen: %0d printed, %0d halts, %0d faults",
             n_in_beats, n_results, n_prints, n_halts, n_faults);
    $display("%0d mismatches over random jobs incl. a full program memory", n_err);
    if (n_err == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// File: filelist.f
design/twm_pkg.sv
design/twm_dpath.sv
design/twm_ctrl.sv
design/toy_word_machine_executor_top.sv
verif/toy_word_machine_executor_top_tb.sv
